// ----- sv/spq_pkg.sv -----
package spq_pkg;

   // queue size and derived widths
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int RANK_W  = 16;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       capture;
      logic       insert;
      logic       remove;
      logic       respond;
      status_type code;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic op_remove;
      logic empty;
      logic full;
   } stat_type;

endpackage

// ----- sv/spq_ctrl.sv -----
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);
   import spq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.code     = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
               busy_in     = 1'b1;
            end
         end
         S_EXEC: begin
            cmd.respond  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            busy_in      = 1'b0;
            if (stat.op_remove) begin
               if (stat.empty) begin
                  cmd.code = ST_EMPTY;
               end else begin
                  cmd.remove = 1'b1;
               end
            end else begin
               if (stat.full) begin
                  cmd.code = ST_FULL;
               end else begin
                  cmd.insert = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/spq_datapath.sv -----
module spq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_pkg::cmd_type                    cmd,
   output spq_pkg::stat_type                   stat,
   input  logic                                req_operation,
   input  logic signed [spq_pkg::VALUE_W-1:0]  req_item_value,
   input  logic        [spq_pkg::RANK_W-1:0]   req_item_rank,
   output logic        [1:0]                   rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic        [spq_pkg::RANK_W-1:0]   rsp_removed_rank,
   output logic        [spq_pkg::CNT_W-1:0]    rsp_occupancy
);
   import spq_pkg::*;

   // captured request
   logic                      op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic        [RANK_W-1:0]  rank_ff;

   // sorted cell array, head at index zero
   logic [VALUE_W-1:0] slot_value_ff [DEPTH];
   logic [RANK_W-1:0]  slot_rank_ff  [DEPTH];
   logic [VALUE_W-1:0] slot_value_in [DEPTH];
   logic [RANK_W-1:0]  slot_rank_in  [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DEPTH-1:0]   keep;

   // response registers
   logic [1:0]                status_ff;
   logic signed [VALUE_W-1:0] rm_value_ff;
   logic        [RANK_W-1:0]  rm_rank_ff;
   logic [CNT_W-1:0]          occ_ff;

   assign stat.op_remove = op_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));

   // cells that stay in place on insert: occupied and rank not above the new one
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) && (slot_rank_ff[i] <= rank_ff);
      end
   end

   // per-cell next value: hold, load new, shift back or shift forward
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_value_in[i] = slot_value_ff[i];
         slot_rank_in[i]  = slot_rank_ff[i];
         if (cmd.insert && !keep[i]) begin
            if (i == 0) begin
               slot_value_in[i] = value_ff;
               slot_rank_in[i]  = rank_ff;
            end else if (keep[i-1]) begin
               slot_value_in[i] = value_ff;
               slot_rank_in[i]  = rank_ff;
            end else begin
               slot_value_in[i] = slot_value_ff[i-1];
               slot_rank_in[i]  = slot_rank_ff[i-1];
            end
         end else if (cmd.remove && (i < DEPTH - 1)) begin
            slot_value_in[i] = slot_value_ff[i+1];
            slot_rank_in[i]  = slot_rank_ff[i+1];
         end
      end
   end

   // occupancy update
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // request capture, cells and response
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         value_ff <= req_item_value;
         rank_ff  <= req_item_rank;
      end
      for (int i = 0; i < DEPTH; i++) begin
         slot_value_ff[i] <= slot_value_in[i];
         slot_rank_ff[i]  <= slot_rank_in[i];
      end
      if (cmd.respond) begin
         status_ff   <= cmd.code;
         rm_value_ff <= cmd.remove ? slot_value_ff[0] : '0;
         rm_rank_ff  <= cmd.remove ? slot_rank_ff[0] : '0;
         occ_ff      <= count_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_removed_value = rm_value_ff;
   assign rsp_removed_rank  = rm_rank_ff;
   assign rsp_occupancy     = occ_ff;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// channel   | direction | handshake          | payload
// request   | in        | start, busy        | req_operation, req_item_value, req_item_rank
// response  | out       | rsp_valid (strobe) | rsp_status, rsp_removed_value,
//           |           |                    | rsp_removed_rank, rsp_occupancy
//
// each request is handled in order: the request registers capture it, then the
// whole sorted cell array shifts in parallel and the response registers load.
// the response strobe is high in the cycle after that load; busy is low in that
// same cycle, so a new request may be taken then.
// reset empties the queue (occupancy zero); cell contents are left as they are.
// the receiver cannot stall: each response is shown for exactly one cycle.
module sorted_priority_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic signed [spq_pkg::VALUE_W-1:0]  req_item_value,
   input  logic        [spq_pkg::RANK_W-1:0]   req_item_rank,
   output logic                                rsp_valid,
   output logic        [1:0]                   rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic        [spq_pkg::RANK_W-1:0]   rsp_removed_rank,
   output logic        [spq_pkg::CNT_W-1:0]    rsp_occupancy
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // cell array and response registers
   spq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_item_value    (req_item_value),
      .req_item_rank     (req_item_rank),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_removed_rank  (rsp_removed_rank),
      .rsp_occupancy     (rsp_occupancy)
   );

   // accepted request makes the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   // a response follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   // full status only when the queue holds every slot
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_occupancy == CNT_W'(DEPTH)))
      else $error("full status with queue not full");

   // empty status reports nothing removed and zero occupancy
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
      (rsp_occupancy == '0 && rsp_removed_value == '0 && rsp_removed_rank == '0))
      else $error("empty status with nonzero fields");

endmodule

// ----- tb/sorted_priority_queue_tb.sv -----
module sorted_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   // request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_ITEMS   = 100;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      status_type                  status;
      logic signed [VALUE_W-1:0]   value;
      logic        [RANK_W-1:0]    rank;
      logic        [CNT_W-1:0]     occupancy;
   } queue_response_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_operation;
   logic signed [VALUE_W-1:0]   req_item_value;
   logic        [RANK_W-1:0]    req_item_rank;
   logic                        rsp_valid;
   logic        [1:0]           rsp_status;
   logic signed [VALUE_W-1:0]   rsp_removed_value;
   logic        [RANK_W-1:0]    rsp_removed_rank;
   logic        [CNT_W-1:0]     rsp_occupancy;

   // shadow copy of the sorted queue
   logic signed [VALUE_W-1:0]   shadow_value [DEPTH];
   logic        [RANK_W-1:0]    shadow_rank  [DEPTH];
   int                          shadow_count;

   queue_response_type          pending_responses [$];
   int                          mismatch_count;
   int                          cycle_count;
   logic                        gaps_on;

   sorted_priority_queue u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_item_value    (req_item_value),
      .req_item_rank     (req_item_rank),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_removed_rank  (rsp_removed_rank),
      .rsp_occupancy     (rsp_occupancy)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // apply one request to the shadow queue and queue up its response
   task automatic predict_queue_response(input logic op, input logic signed [VALUE_W-1:0] val,
                                         input logic [RANK_W-1:0] rank);
      queue_response_type rsp;
      int                 pos;
      int                 i;
      rsp.status = ST_OK;
      rsp.value  = '0;
      rsp.rank   = '0;
      if (op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            rsp.status = ST_FULL;
         end else begin
            // new entry goes behind every entry of lower or equal rank
            pos = 0;
            while (pos < shadow_count && shadow_rank[pos] <= rank) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_rank[i]  = shadow_rank[i-1];
            end
            shadow_value[pos] = val;
            shadow_rank[pos]  = rank;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            rsp.value = shadow_value[0];
            rsp.rank  = shadow_rank[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_value[i-1] = shadow_value[i];
               shadow_rank[i-1]  = shadow_rank[i];
            end
            shadow_count--;
         end
      end
      rsp.occupancy = shadow_count[CNT_W-1:0];
      pending_responses.push_back(rsp);
   endtask

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   // response checker, sampled mid-cycle
   always @(negedge clock) begin
      queue_response_type exp_rsp;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_responses.size() == 0) begin
            note_failure($sformatf("unexpected response: status %0d value %0d rank %0d occ %0d",
                                   rsp_status, rsp_removed_value, rsp_removed_rank,
                                   rsp_occupancy));
         end else begin
            exp_rsp = pending_responses.pop_front();
            if (rsp_status !== exp_rsp.status || rsp_removed_value !== exp_rsp.value ||
                rsp_removed_rank !== exp_rsp.rank || rsp_occupancy !== exp_rsp.occupancy) begin
               note_failure($sformatf(
                  "mismatch: expected status %0d value %0d rank %0d occ %0d, got %0d %0d %0d %0d",
                  exp_rsp.status, exp_rsp.value, exp_rsp.rank, exp_rsp.occupancy,
                  rsp_status, rsp_removed_value, rsp_removed_rank, rsp_occupancy));
            end
         end
      end
   end

   // send one request, with an optional idle burst ahead of it
   task automatic send_request(input logic op, input logic signed [VALUE_W-1:0] val,
                               input logic [RANK_W-1:0] rank);
      logic taken;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start          <= 1'b1;
      req_operation  <= op;
      req_item_value <= val;
      req_item_rank  <= rank;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      predict_queue_response(op, val, rank);
   endtask

   // stop sending and let every outstanding response arrive
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [RANK_W-1:0] random_rank();
      case ($urandom_range(0, 3))
         0: return RANK_W'($urandom_range(0, 7));
         1: return $urandom_range(0, 1) ? '1 : '0;
         default: return RANK_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(VALUE_W-1){1'b0}}};
         1: return {1'b0, {(VALUE_W-1){1'b1}}};
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic test_remove_from_empty();
      send_request(OP_REMOVE, 32'sh5a5a_a5a5, 16'hffff);
      send_request(OP_REMOVE, '0, '0);
   endtask

   // extremes of value and rank, equal ranks served first in first out
   task automatic test_rank_order_and_ties();
      send_request(OP_INSERT, {1'b0, {(VALUE_W-1){1'b1}}}, 16'hffff);
      send_request(OP_INSERT, {1'b1, {(VALUE_W-1){1'b0}}}, 16'h0000);
      send_request(OP_INSERT, -32'sd1, 16'h0000);
      send_request(OP_INSERT, 32'sd0, 16'd5);
      send_request(OP_INSERT, 32'sd1, 16'd5);
      send_request(OP_INSERT, 32'sd2, 16'd5);
      repeat (4) send_request(OP_REMOVE, random_value(), random_rank());
   endtask

   // fill up including ties at the top rank, then insert into a full queue
   task automatic test_overflow_when_full();
      while (shadow_count < DEPTH)
         send_request(OP_INSERT, random_value(),
                      $urandom_range(0, 1) ? 16'hffff : RANK_W'($urandom_range(0, 3)));
      send_request(OP_INSERT, random_value(), 16'h0000);
      send_request(OP_INSERT, random_value(), random_rank());
   endtask

   // mixed traffic; insert share varies so occupancy sweeps empty to full
   task automatic test_random_traffic();
      int insert_pct;
      int n;
      insert_pct = 20;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: insert_pct = 15;
               1: insert_pct = 50;
               2: insert_pct = 80;
               default: insert_pct = 95;
            endcase
         end
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         send_request(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                      random_value(), random_rank());
      end
   endtask

   // back-to-back requests with no idle cycles
   task automatic test_back_to_back();
      int n;
      gaps_on = 1'b0;
      for (n = 0; n < TAIL_ITEMS; n++)
         send_request($urandom_range(0, 1) ? OP_INSERT : OP_REMOVE,
                      random_value(), random_rank());
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_operation  = OP_INSERT;
      req_item_value = '0;
      req_item_rank  = '0;
      shadow_count   = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      gaps_on        = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_remove_from_empty();
      test_rank_order_and_ties();
      test_overflow_when_full();
      test_random_traffic();
      test_back_to_back();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
